// ===== rtl/core/jmsp_pkg.sv =====
package jmsp_pkg;

  localparam int unsigned IdxW = 17;

  typedef enum logic [2:0] {
    PH_SOI0 = 3'd0,
    PH_SOI1 = 3'd1,
    PH_APP0 = 3'd2,
    PH_BODY = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_COMMENT   = 3'd0;
  localparam logic [2:0] KIND_SEPARATOR = 3'd1;
  localparam logic [2:0] KIND_DIMS      = 3'd2;
  localparam logic [2:0] KIND_FINISHED  = 3'd3;
  localparam logic [2:0] KIND_SHORT     = 3'd4;
  localparam logic [2:0] KIND_NOSOI     = 3'd5;
  localparam logic [2:0] KIND_BADAPP0   = 3'd6;
  localparam logic [2:0] KIND_TRUNC     = 3'd7;

  localparam logic [7:0] BYTE_FF      = 8'hFF;
  localparam logic [7:0] MARKER_SOI   = 8'hD8;
  localparam logic [7:0] MARKER_APP0  = 8'hE0;
  localparam logic [7:0] MARKER_SOF0  = 8'hC0;
  localparam logic [7:0] MARKER_COM   = 8'hFE;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  typedef struct packed {
    logic        vld;
    logic [2:0]  kind;
    logic [7:0]  cbyte;
    logic [15:0] width;
    logic [15:0] height;
  } res_t;

  // "JFIF" followed by a zero byte
  function automatic logic [7:0] jfif_sig(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h4A;
      3'd1:    ch = 8'h46;
      3'd2:    ch = 8'h49;
      3'd3:    ch = 8'h46;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/jmsp_parser.sv =====
module jmsp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  logic              eof_in,
  output jmsp_pkg::res_t    res
);

  jmsp_pkg::phase_t              phase_r, phase_nxt;
  logic [jmsp_pkg::IdxW-1:0]     idx_r, idx_nxt;
  logic [jmsp_pkg::IdxW-1:0]     total_r, total_nxt;
  logic [7:0]                    marker_r, marker_nxt;
  logic [15:0]                   height_r, height_nxt;
  logic [15:0]                   width_r, width_nxt;
  logic                          jfif_r, jfif_nxt;
  logic                          seen_r, seen_nxt;

  logic                          app, body, seg;
  logic                          idx0, idx1, idx2, idx3, idx_hi;
  logic [15:0]                   len;
  logic                          len_bad, sig_bad, jfif_upd, abort;
  logic [jmsp_pkg::IdxW-1:0]     total_upd, idx_inc;
  logic [15:0]                   height_upd, width_upd;
  logic                          sof0, com, seg_end;

  assign app    = (phase_r == jmsp_pkg::PH_APP0);
  assign body   = (phase_r == jmsp_pkg::PH_BODY);
  assign seg    = app || body;
  assign idx0   = (idx_r == 17'd0);
  assign idx1   = (idx_r == 17'd1);
  assign idx2   = (idx_r == 17'd2);
  assign idx3   = (idx_r == 17'd3);
  assign idx_hi = (idx_r >= 17'd4);
  assign sof0   = body && (marker_r == jmsp_pkg::MARKER_SOF0);
  assign com    = body && (marker_r == jmsp_pkg::MARKER_COM);

  // length field, high byte parked in total_r at index 2
  assign len     = {total_r[15:8], byte_in};
  assign len_bad = app ? (len < 16'd7) : (len < 16'd2);

  assign sig_bad  = app && idx_hi && (idx_r <= 17'd8) &&
                    (byte_in != jmsp_pkg::jfif_sig(idx_r[2:0] - 3'd4));
  assign jfif_upd = jfif_r && !sig_bad;

  assign abort = seg && ((idx0 && byte_in != jmsp_pkg::BYTE_FF) ||
                         (idx1 && app && byte_in != jmsp_pkg::MARKER_APP0) ||
                         (idx3 && len_bad) ||
                         (app && idx_r == 17'd8 && !jfif_upd));

  always_comb begin
    total_upd = total_r;
    if (idx2) begin
      total_upd = {1'b0, byte_in, 8'h00};
    end else if (idx3) begin
      total_upd = {1'b0, len} + 17'd2;
    end
  end

  always_comb begin
    height_upd = height_r;
    width_upd  = width_r;
    if (sof0) begin
      case (idx_r)
        17'd5:   height_upd = {byte_in, 8'h00};
        17'd6:   height_upd = height_r | {8'h00, byte_in};
        17'd7:   width_upd  = {byte_in, 8'h00};
        17'd8:   width_upd  = width_r | {8'h00, byte_in};
        default: ;
      endcase
    end
  end

  assign idx_inc = idx_r + 17'd1;
  assign seg_end = (idx_inc >= 17'd4) && (idx_inc >= total_upd);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    marker_nxt = marker_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    jfif_nxt   = jfif_r;
    seen_nxt   = seen_r;
    if (eof_in) begin
      phase_nxt  = jmsp_pkg::PH_SOI0;
      idx_nxt    = '0;
      total_nxt  = '0;
      marker_nxt = '0;
      height_nxt = '0;
      width_nxt  = '0;
      jfif_nxt   = 1'b1;
      seen_nxt   = 1'b0;
    end else begin
      case (phase_r)
        jmsp_pkg::PH_SOI0: begin
          marker_nxt = byte_in;
          phase_nxt  = jmsp_pkg::PH_SOI1;
        end
        jmsp_pkg::PH_SOI1: begin
          if (marker_r == jmsp_pkg::BYTE_FF && byte_in == jmsp_pkg::MARKER_SOI) begin
            phase_nxt = jmsp_pkg::PH_APP0;
            idx_nxt   = '0;
            jfif_nxt  = 1'b1;
          end else begin
            phase_nxt = jmsp_pkg::PH_DONE;
          end
        end
        jmsp_pkg::PH_APP0, jmsp_pkg::PH_BODY: begin
          if (idx1) begin
            marker_nxt = byte_in;
          end
          jfif_nxt   = jfif_upd;
          height_nxt = height_upd;
          width_nxt  = width_upd;
          if (com && idx_hi) begin
            seen_nxt = 1'b1;
          end
          if (abort) begin
            phase_nxt = jmsp_pkg::PH_DONE;
            if (!idx0) begin
              total_nxt = total_upd;
            end
          end else begin
            total_nxt = total_upd;
            if (seg_end) begin
              idx_nxt = '0;
              if (app) begin
                phase_nxt = jmsp_pkg::PH_BODY;
              end
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result of this byte
  always_comb begin
    res = '0;
    if (eof_in) begin
      case (phase_r)
        jmsp_pkg::PH_SOI0, jmsp_pkg::PH_SOI1: begin
          res.vld  = 1'b1;
          res.kind = jmsp_pkg::KIND_SHORT;
        end
        jmsp_pkg::PH_APP0: begin
          res.vld  = 1'b1;
          res.kind = jmsp_pkg::KIND_BADAPP0;
        end
        jmsp_pkg::PH_BODY: begin
          res.vld  = 1'b1;
          res.kind = idx_hi ? jmsp_pkg::KIND_TRUNC : jmsp_pkg::KIND_FINISHED;
        end
        default: ;
      endcase
    end else if (phase_r == jmsp_pkg::PH_SOI1) begin
      if (!(marker_r == jmsp_pkg::BYTE_FF && byte_in == jmsp_pkg::MARKER_SOI)) begin
        res.vld  = 1'b1;
        res.kind = jmsp_pkg::KIND_NOSOI;
      end
    end else if (abort) begin
      res.vld  = 1'b1;
      res.kind = app ? jmsp_pkg::KIND_BADAPP0 : jmsp_pkg::KIND_FINISHED;
    end else if (com && idx3 && seen_r) begin
      res.vld   = 1'b1;
      res.kind  = jmsp_pkg::KIND_SEPARATOR;
      res.cbyte = jmsp_pkg::NEWLINE_CODE;
    end else if (com && idx_hi) begin
      res.vld   = 1'b1;
      res.kind  = jmsp_pkg::KIND_COMMENT;
      res.cbyte = byte_in;
    end else if (sof0 && seg_end && total_upd >= 17'd9) begin
      res.vld    = 1'b1;
      res.kind   = jmsp_pkg::KIND_DIMS;
      res.width  = width_upd;
      res.height = height_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= jmsp_pkg::PH_SOI0;
      idx_r    <= '0;
      total_r  <= '0;
      marker_r <= '0;
      height_r <= '0;
      width_r  <= '0;
      jfif_r   <= 1'b1;
      seen_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      total_r  <= total_nxt;
      marker_r <= marker_nxt;
      height_r <= height_nxt;
      width_r  <= width_nxt;
      jfif_r   <= jfif_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

// ===== rtl/core/jpeg_marker_segment_parser_top.sv =====
// JPEG/JFIF marker segment parser. Feed the file one byte per in_ word; a
// word with in_tlast set marks end of file, carries no byte and re-arms the
// parser for the next file. Each input word yields at most one result word,
// always with out_tlast set: comment bytes, a newline separator between
// comments, the SOF0 dimensions, or a final status (kind in out_tuser).
// After a status, bytes are dropped until end of file. A truncated status
// means the last comment may be partial. Throughput is one byte per clock;
// a byte is held in the input register while the parser state updates, and
// its result is then written into the output register. A result word held
// by out_tready low stalls the next byte.
module jpeg_marker_segment_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] comment_byte, [23:8] pic_width,
                                  // [39:24] pic_height
  output logic [2:0]  out_tuser,  // [2:0] result_kind
  output logic        out_tlast   // last_of_run
);

  logic           in_v_r, in_v_nxt;
  logic [7:0]     in_byte_r;
  logic           in_eof_r;
  logic           out_v_r, out_v_nxt;
  logic [39:0]    out_data_r;
  logic [2:0]     out_kind_r;
  logic           fire;
  jmsp_pkg::res_t res;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  jmsp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .byte_in (in_byte_r),
    .eof_in  (in_eof_r),
    .res     (res)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = res.vld;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
    if (fire && res.vld) begin
      out_data_r <= {res.height, res.width, res.cbyte};
      out_kind_r <= res.kind;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  // every word is the only result of its byte
  assign out_tlast  = 1'b1;

endmodule

// ===== rtl/core/jmsp_checker.sv =====
module jmsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_sep_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == jmsp_pkg::KIND_SEPARATOR |->
      out_tdata[7:0] == jmsp_pkg::NEWLINE_CODE && out_tdata[39:8] == 32'd0)
    else $error("separator word malformed");

  a_dims_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != jmsp_pkg::KIND_DIMS |-> out_tdata[39:8] == 32'd0)
    else $error("dimensions present on a non-dimension word");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != jmsp_pkg::KIND_COMMENT &&
    out_tuser != jmsp_pkg::KIND_SEPARATOR |-> out_tdata[7:0] == 8'd0 && out_tlast)
    else $error("status word carries a byte");

  a_empty_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result word present right after reset");

endmodule

bind jpeg_marker_segment_parser_top jmsp_checker u_jmsp_checker (.*);
